// ===== hw/rtl/rbi_pkg.sv =====
// shared types, constants and saturating arithmetic for the rigid body integrator
package rbi_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int UCFG_W    = WORD_W - 1;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [UCFG_W-1:0] INV_MASS_RST = UCFG_W'(65536);
	localparam logic [UCFG_W-1:0] INV_INR_RST  = UCFG_W'(65536);
	localparam logic [UCFG_W-1:0] DT_RST       = UCFG_W'(1092);

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_FORCE   = 3'd0,
		OP_CONTACT = 3'd1,
		OP_STEP    = 3'd2,
		OP_RESET   = 3'd3,
		OP_QUERY   = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_MASS    = 3'd0,
		CFG_INV_INERTIA = 3'd1,
		CFG_TIME_STEP   = 3'd2,
		CFG_START_X     = 3'd3,
		CFG_START_Y     = 3'd4,
		CFG_START_ANGLE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		word_t           point_x;
		word_t           point_y;
		word_t           force_x;
		word_t           force_y;
	} req_t;

	typedef struct packed {
		word_t pos_x;
		word_t pos_y;
		word_t angle;
		word_t vel_x;
		word_t vel_y;
		word_t spin;
		word_t point_vel_x;
		word_t point_vel_y;
	} res_t;

	typedef enum logic [4:0] {
		SRC_ZERO, SRC_PROD, SRC_T0, SRC_T1, SRC_PX, SRC_PY, SRC_FX, SRC_FY,
		SRC_BX, SRC_BY, SRC_ANG, SRC_VX, SRC_VY, SRC_AV, SRC_FAX, SRC_FAY,
		SRC_TQ, SRC_IMASS, SRC_IINR, SRC_DT
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_T0, DST_T1, DST_FAX, DST_FAY, DST_TQ, DST_AV, DST_ANG,
		DST_VX, DST_VY, DST_BX, DST_BY, DST_PVX, DST_PVY
	} dst_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FRC0, ST_FRC1,
		ST_CON0, ST_CON1, ST_CON2, ST_CON3, ST_CON4, ST_CON5, ST_CON6,
		ST_STP0, ST_STP1, ST_STP2, ST_STP3, ST_STP4,
		ST_STP5, ST_STP6, ST_STP7, ST_STP8, ST_STP9,
		ST_CLR, ST_RST,
		ST_QRY0, ST_QRY1, ST_QRY2, ST_QRY3, ST_QRY4,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic mul_en;
		src_t mul_a;
		src_t mul_b;
		src_t add_a;
		src_t add_b;
		logic add_sub;
		dst_t add_dst;
		logic clr_acc;
		logic load_pose;
		logic load_out;
	} uop_t;

	function automatic word_t sat_addsub(input word_t a, input word_t b, input logic sub);
		logic signed [WORD_W:0] s;
		s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b})
		        : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end
		return s[WORD_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/rbi_mul.sv =====
// shared signed fixed point multiplier with registered product and saturation
module rbi_mul (
	input  logic          clk,
	input  logic          en,
	input  rbi_pkg::word_t a,
	input  rbi_pkg::word_t b,
	output rbi_pkg::word_t r
);

	localparam int W    = rbi_pkg::WORD_W;
	localparam int HI_W = 2 * W - rbi_pkg::FRAC_W;
	localparam logic [HI_W-1:0] POS_LIM = (HI_W'(1) << (W - 1)) - HI_W'(1);
	localparam logic [HI_W-1:0] NEG_LIM = HI_W'(1) << (W - 1);

	logic [W-1:0]    mag_a;
	logic [W-1:0]    mag_b;
	logic [2*W-1:0]  mag_q;
	logic            neg_q;
	logic [HI_W-1:0] hi;

	assign mag_a = a[W-1] ? (-a) : a;
	assign mag_b = b[W-1] ? (-b) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= mag_a * mag_b;
			neg_q <= a[W-1] ^ b[W-1];
		end
	end

	assign hi = mag_q[2*W-1:rbi_pkg::FRAC_W];

	always_comb begin
		if (neg_q) begin
			if (hi > NEG_LIM) r = {1'b1, {(W-1){1'b0}}};
			else r = -hi[W-1:0];
		end else begin
			if (hi > POS_LIM) r = {1'b0, {(W-1){1'b1}}};
			else r = hi[W-1:0];
		end
	end

endmodule

// ===== hw/rtl/rbi_seq.sv =====
// sequencer that walks the shared multiplier and adder through each opcode
module rbi_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [rbi_pkg::OP_W-1:0]    opcode,
	input  logic                        mass_zero,
	input  logic                        res_stall,
	output logic                        req_stall,
	output logic                        res_valid,
	output rbi_pkg::uop_t               uop
);

	rbi_pkg::state_t state_q, state_d;
	logic            res_valid_q;
	logic            out_blocked;

	assign out_blocked = res_valid_q && res_stall;
	assign req_stall   = (state_q != rbi_pkg::ST_IDLE);
	assign res_valid   = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbi_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (uop.load_out) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbi_pkg::ST_IDLE: begin
				if (req_valid) begin
					priority case (opcode)
						rbi_pkg::OP_FORCE:   state_d = rbi_pkg::ST_FRC0;
						rbi_pkg::OP_CONTACT: state_d = rbi_pkg::ST_CON0;
						rbi_pkg::OP_STEP:    state_d = mass_zero ? rbi_pkg::ST_CLR
						                                         : rbi_pkg::ST_STP0;
						rbi_pkg::OP_RESET:   state_d = rbi_pkg::ST_RST;
						rbi_pkg::OP_QUERY:   state_d = rbi_pkg::ST_QRY0;
						default:             state_d = rbi_pkg::ST_DONE;
					endcase
				end
			end
			rbi_pkg::ST_FRC0: state_d = rbi_pkg::ST_FRC1;
			rbi_pkg::ST_FRC1: state_d = rbi_pkg::ST_DONE;
			rbi_pkg::ST_CON0: state_d = rbi_pkg::ST_CON1;
			rbi_pkg::ST_CON1: state_d = rbi_pkg::ST_CON2;
			rbi_pkg::ST_CON2: state_d = rbi_pkg::ST_CON3;
			rbi_pkg::ST_CON3: state_d = rbi_pkg::ST_CON4;
			rbi_pkg::ST_CON4: state_d = rbi_pkg::ST_CON5;
			rbi_pkg::ST_CON5: state_d = rbi_pkg::ST_CON6;
			rbi_pkg::ST_CON6: state_d = rbi_pkg::ST_DONE;
			rbi_pkg::ST_STP0: state_d = rbi_pkg::ST_STP1;
			rbi_pkg::ST_STP1: state_d = rbi_pkg::ST_STP2;
			rbi_pkg::ST_STP2: state_d = rbi_pkg::ST_STP3;
			rbi_pkg::ST_STP3: state_d = rbi_pkg::ST_STP4;
			rbi_pkg::ST_STP4: state_d = rbi_pkg::ST_STP5;
			rbi_pkg::ST_STP5: state_d = rbi_pkg::ST_STP6;
			rbi_pkg::ST_STP6: state_d = rbi_pkg::ST_STP7;
			rbi_pkg::ST_STP7: state_d = rbi_pkg::ST_STP8;
			rbi_pkg::ST_STP8: state_d = rbi_pkg::ST_STP9;
			rbi_pkg::ST_STP9: state_d = rbi_pkg::ST_DONE;
			rbi_pkg::ST_CLR:  state_d = rbi_pkg::ST_DONE;
			rbi_pkg::ST_RST:  state_d = rbi_pkg::ST_DONE;
			rbi_pkg::ST_QRY0: state_d = rbi_pkg::ST_QRY1;
			rbi_pkg::ST_QRY1: state_d = rbi_pkg::ST_QRY2;
			rbi_pkg::ST_QRY2: state_d = rbi_pkg::ST_QRY3;
			rbi_pkg::ST_QRY3: state_d = rbi_pkg::ST_QRY4;
			rbi_pkg::ST_QRY4: state_d = rbi_pkg::ST_DONE;
			rbi_pkg::ST_DONE: state_d = out_blocked ? rbi_pkg::ST_DONE : rbi_pkg::ST_IDLE;
			default:          state_d = rbi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		uop           = '0;
		uop.mul_a     = rbi_pkg::SRC_ZERO;
		uop.mul_b     = rbi_pkg::SRC_ZERO;
		uop.add_a     = rbi_pkg::SRC_ZERO;
		uop.add_b     = rbi_pkg::SRC_ZERO;
		uop.add_dst   = rbi_pkg::DST_NONE;
		unique case (state_q)
			rbi_pkg::ST_IDLE: uop.take = req_valid;
			// force accumulate
			rbi_pkg::ST_FRC0, rbi_pkg::ST_CON5: begin
				uop.add_a = rbi_pkg::SRC_FAX; uop.add_b = rbi_pkg::SRC_FX;
				uop.add_dst = rbi_pkg::DST_FAX;
			end
			rbi_pkg::ST_FRC1, rbi_pkg::ST_CON6: begin
				uop.add_a = rbi_pkg::SRC_FAY; uop.add_b = rbi_pkg::SRC_FY;
				uop.add_dst = rbi_pkg::DST_FAY;
			end
			// lever arm and torque
			rbi_pkg::ST_CON0, rbi_pkg::ST_QRY0: begin
				uop.add_a = rbi_pkg::SRC_PX; uop.add_b = rbi_pkg::SRC_BX;
				uop.add_sub = 1'b1; uop.add_dst = rbi_pkg::DST_T0;
			end
			rbi_pkg::ST_CON1: begin
				uop.add_a = rbi_pkg::SRC_PY; uop.add_b = rbi_pkg::SRC_BY;
				uop.add_sub = 1'b1; uop.add_dst = rbi_pkg::DST_T1;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_T0; uop.mul_b = rbi_pkg::SRC_FY;
			end
			rbi_pkg::ST_CON2: begin
				uop.add_a = rbi_pkg::SRC_PROD; uop.add_dst = rbi_pkg::DST_T0;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_T1; uop.mul_b = rbi_pkg::SRC_FX;
			end
			rbi_pkg::ST_CON3: begin
				uop.add_a = rbi_pkg::SRC_T0; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_sub = 1'b1; uop.add_dst = rbi_pkg::DST_T0;
			end
			rbi_pkg::ST_CON4: begin
				uop.add_a = rbi_pkg::SRC_TQ; uop.add_b = rbi_pkg::SRC_T0;
				uop.add_dst = rbi_pkg::DST_TQ;
			end
			// integration step
			rbi_pkg::ST_STP0: begin
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_IINR; uop.mul_b = rbi_pkg::SRC_TQ;
			end
			rbi_pkg::ST_STP1, rbi_pkg::ST_STP3, rbi_pkg::ST_STP6: begin
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_PROD; uop.mul_b = rbi_pkg::SRC_DT;
			end
			rbi_pkg::ST_STP2: begin
				uop.add_a = rbi_pkg::SRC_AV; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_AV;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_IMASS; uop.mul_b = rbi_pkg::SRC_FAX;
			end
			rbi_pkg::ST_STP4: begin
				uop.add_a = rbi_pkg::SRC_VX; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_VX;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_AV; uop.mul_b = rbi_pkg::SRC_DT;
			end
			rbi_pkg::ST_STP5: begin
				uop.add_a = rbi_pkg::SRC_ANG; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_ANG;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_IMASS; uop.mul_b = rbi_pkg::SRC_FAY;
			end
			rbi_pkg::ST_STP7: begin
				uop.add_a = rbi_pkg::SRC_VY; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_VY;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_VX; uop.mul_b = rbi_pkg::SRC_DT;
			end
			rbi_pkg::ST_STP8: begin
				uop.add_a = rbi_pkg::SRC_BX; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_BX;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_VY; uop.mul_b = rbi_pkg::SRC_DT;
			end
			rbi_pkg::ST_STP9: begin
				uop.add_a = rbi_pkg::SRC_BY; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_BY; uop.clr_acc = 1'b1;
			end
			rbi_pkg::ST_CLR: uop.clr_acc = 1'b1;
			rbi_pkg::ST_RST: uop.load_pose = 1'b1;
			// point velocity
			rbi_pkg::ST_QRY1: begin
				uop.add_a = rbi_pkg::SRC_PY; uop.add_b = rbi_pkg::SRC_BY;
				uop.add_sub = 1'b1; uop.add_dst = rbi_pkg::DST_T1;
			end
			rbi_pkg::ST_QRY2: begin
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_AV; uop.mul_b = rbi_pkg::SRC_T1;
			end
			rbi_pkg::ST_QRY3: begin
				uop.add_a = rbi_pkg::SRC_VX; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_sub = 1'b1; uop.add_dst = rbi_pkg::DST_PVX;
				uop.mul_en = 1'b1; uop.mul_a = rbi_pkg::SRC_AV; uop.mul_b = rbi_pkg::SRC_T0;
			end
			rbi_pkg::ST_QRY4: begin
				uop.add_a = rbi_pkg::SRC_VY; uop.add_b = rbi_pkg::SRC_PROD;
				uop.add_dst = rbi_pkg::DST_PVY;
			end
			rbi_pkg::ST_DONE: uop.load_out = !out_blocked;
			default: uop.take = 1'b0;
		endcase
	end

endmodule

// ===== hw/rtl/rbi_dp.sv =====
// datapath: body state, configuration, operand selection, shared adder and result register
module rbi_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rbi_pkg::uop_t                    uop,
	input  rbi_pkg::req_t                    req,
	input  logic                             cfg_we,
	input  logic [rbi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  rbi_pkg::word_t                   cfg_data,
	output logic                             mass_zero,
	output rbi_pkg::res_t                    res
);

	localparam int UW = rbi_pkg::UCFG_W;

	logic [UW-1:0]  inv_mass_q, inv_inr_q, dt_q;
	rbi_pkg::word_t start_x_q, start_y_q, start_ang_q;
	rbi_pkg::word_t bx_q, by_q, ang_q, vx_q, vy_q, av_q, fax_q, fay_q, tq_q;
	rbi_pkg::word_t t0_q, t1_q, pvx_q, pvy_q;
	rbi_pkg::req_t  req_q;
	rbi_pkg::res_t  res_q;
	rbi_pkg::word_t prod, mul_a, mul_b, add_a, add_b, sum;

	function automatic rbi_pkg::word_t pick(input rbi_pkg::src_t s);
		rbi_pkg::word_t v;
		unique case (s)
			rbi_pkg::SRC_ZERO:  v = '0;
			rbi_pkg::SRC_PROD:  v = prod;
			rbi_pkg::SRC_T0:    v = t0_q;
			rbi_pkg::SRC_T1:    v = t1_q;
			rbi_pkg::SRC_PX:    v = req_q.point_x;
			rbi_pkg::SRC_PY:    v = req_q.point_y;
			rbi_pkg::SRC_FX:    v = req_q.force_x;
			rbi_pkg::SRC_FY:    v = req_q.force_y;
			rbi_pkg::SRC_BX:    v = bx_q;
			rbi_pkg::SRC_BY:    v = by_q;
			rbi_pkg::SRC_ANG:   v = ang_q;
			rbi_pkg::SRC_VX:    v = vx_q;
			rbi_pkg::SRC_VY:    v = vy_q;
			rbi_pkg::SRC_AV:    v = av_q;
			rbi_pkg::SRC_FAX:   v = fax_q;
			rbi_pkg::SRC_FAY:   v = fay_q;
			rbi_pkg::SRC_TQ:    v = tq_q;
			rbi_pkg::SRC_IMASS: v = {1'b0, inv_mass_q};
			rbi_pkg::SRC_IINR:  v = {1'b0, inv_inr_q};
			rbi_pkg::SRC_DT:    v = {1'b0, dt_q};
			default:            v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mul_a = pick(uop.mul_a);
		mul_b = pick(uop.mul_b);
		add_a = pick(uop.add_a);
		add_b = pick(uop.add_b);
	end

	assign sum = rbi_pkg::sat_addsub(add_a, add_b, uop.add_sub);

	rbi_mul u_mul (
		.clk (clk),
		.en  (uop.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.r   (prod)
	);

	assign mass_zero = (inv_mass_q == '0);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q  <= rbi_pkg::INV_MASS_RST;
			inv_inr_q   <= rbi_pkg::INV_INR_RST;
			dt_q        <= rbi_pkg::DT_RST;
			start_x_q   <= '0;
			start_y_q   <= '0;
			start_ang_q <= '0;
		end else if (cfg_we) begin
			priority case (cfg_index)
				rbi_pkg::CFG_INV_MASS:    inv_mass_q  <= cfg_data[UW-1:0];
				rbi_pkg::CFG_INV_INERTIA: inv_inr_q   <= cfg_data[UW-1:0];
				rbi_pkg::CFG_TIME_STEP:   dt_q        <= cfg_data[UW-1:0];
				rbi_pkg::CFG_START_X:     start_x_q   <= cfg_data;
				rbi_pkg::CFG_START_Y:     start_y_q   <= cfg_data;
				rbi_pkg::CFG_START_ANGLE: start_ang_q <= cfg_data;
				default:                  start_ang_q <= start_ang_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q  <= '0;
			by_q  <= '0;
			ang_q <= '0;
			vx_q  <= '0;
			vy_q  <= '0;
			av_q  <= '0;
			fax_q <= '0;
			fay_q <= '0;
			tq_q  <= '0;
		end else begin
			unique case (uop.add_dst)
				rbi_pkg::DST_FAX: fax_q <= sum;
				rbi_pkg::DST_FAY: fay_q <= sum;
				rbi_pkg::DST_TQ:  tq_q  <= sum;
				rbi_pkg::DST_AV:  av_q  <= sum;
				rbi_pkg::DST_ANG: ang_q <= sum;
				rbi_pkg::DST_VX:  vx_q  <= sum;
				rbi_pkg::DST_VY:  vy_q  <= sum;
				rbi_pkg::DST_BX:  bx_q  <= sum;
				rbi_pkg::DST_BY:  by_q  <= sum;
				default: begin
				end
			endcase
			if (uop.clr_acc) begin
				fax_q <= '0;
				fay_q <= '0;
				tq_q  <= '0;
			end
			if (uop.load_pose) begin
				bx_q  <= start_x_q;
				by_q  <= start_y_q;
				ang_q <= start_ang_q;
				vx_q  <= '0;
				vy_q  <= '0;
				av_q  <= '0;
				fax_q <= '0;
				fay_q <= '0;
				tq_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uop.take) begin
			req_q <= req;
			pvx_q <= '0;
			pvy_q <= '0;
		end
		unique case (uop.add_dst)
			rbi_pkg::DST_T0:  t0_q  <= sum;
			rbi_pkg::DST_T1:  t1_q  <= sum;
			rbi_pkg::DST_PVX: pvx_q <= sum;
			rbi_pkg::DST_PVY: pvy_q <= sum;
			default:          t0_q  <= t0_q;
		endcase
		if (uop.load_out) begin
			res_q.pos_x       <= bx_q;
			res_q.pos_y       <= by_q;
			res_q.angle       <= ang_q;
			res_q.vel_x       <= vx_q;
			res_q.vel_y       <= vy_q;
			res_q.spin        <= av_q;
			res_q.point_vel_x <= pvx_q;
			res_q.point_vel_y <= pvy_q;
		end
	end

endmodule

// ===== hw/rtl/rigid_body_2d_integrator_top.sv =====
// top level of the 2d rigid body integrator
// One rigid body in signed Q16.16 with saturating arithmetic throughout. A request carries an
// opcode (add force, add contact force, step, reset to start pose, point velocity query) and
// returns exactly one result with the pose and velocities after the request. Requests are
// handled one at a time by a sequencer driving a single saturating multiplier (product
// registered) and a single saturating adder; req_stall stays high while a request is in
// work. A request walks the states of its opcode (an unused opcode has none) and then a
// done state that places the result in the output register. The length of a step is set
// by its nine products and six sums in that one multiplier and adder. A finished result
// waits in the output register, and the next request is taken while it waits; a result that
// cannot be placed because the previous one is still stalled holds the block. Configuration
// registers are written at any time through the cfg port, which is always ready, but are
// meant to change only while the block is idle.
module rigid_body_2d_integrator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  rbi_pkg::req_t                    req,
	output logic                             res_valid,
	input  logic                             res_stall,
	output rbi_pkg::res_t                    res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rbi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  rbi_pkg::word_t                   cfg_data
);

	rbi_pkg::uop_t uop;
	logic          mass_zero;

	assign cfg_ready = 1'b1;

	rbi_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (req.opcode),
		.mass_zero (mass_zero),
		.res_stall (res_stall),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.uop       (uop)
	);

	rbi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop       (uop),
		.req       (req),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mass_zero (mass_zero),
		.res       (res)
	);

endmodule

// ===== hw/rtl/rbi_chk.sv =====
// port level checker for the rigid body integrator and its bind
module rbi_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          res_valid,
	input logic          res_stall,
	input rbi_pkg::res_t res
);

	// busy right after a request is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while block not busy afterwards");

	// no result appears in the cycle right after a request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(res_valid))
		else $error("result too early");

	// a new result only comes out of a busy block
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_stall))
		else $error("result without work");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

endmodule

bind rigid_body_2d_integrator_top rbi_chk u_rbi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== tb/rigid_body_2d_integrator_top_test.sv =====
// self-checking testbench for the 2d rigid body integrator with its own fixed-point body model
module rigid_body_2d_integrator_top_test;
	import rbi_pkg::*;

	localparam int    PHASES          = 6;
	localparam int    REQS_PER_PHASE  = 310;
	localparam int    SETTLE_CYCLES   = 16;
	localparam int    CYCLE_LIMIT     = 400000;
	localparam word_t WORD_MAX        = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN        = {1'b1, {(WORD_W-1){1'b0}}};
	localparam word_t UCFG_MASK       = {1'b0, {UCFG_W{1'b1}}};
	localparam word_t ONE_Q           = word_t'(1) <<< FRAC_W;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	word_t                cfg_data = '0;

	// body model state and register copies
	word_t pos_x_q, pos_y_q, angle_q, vel_x_q, vel_y_q, spin_q;
	word_t force_x_q, force_y_q, torque_q;
	word_t inv_mass_cfg, inv_inertia_cfg, dt_cfg, start_x_cfg, start_y_cfg, start_angle_cfg;

	req_t pending_reqs[$];
	res_t awaited_states[$];
	int   src_idle_pct = 0;
	int   sink_idle_pct = 0;
	int   mismatch_count = 0;
	int   reqs_queued = 0;
	int   results_checked = 0;
	int   steps_moving = 0;
	int   steps_static = 0;
	int   cycle_count = 0;

	rigid_body_2d_integrator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic word_t clamp_word(longint v);
		if (v > longint'(WORD_MAX))
			return WORD_MAX;
		if (v < longint'(WORD_MIN))
			return WORD_MIN;
		return word_t'(v);
	endfunction

	function automatic word_t sat_sum(word_t a, word_t b);
		return clamp_word(longint'(a) + longint'(b));
	endfunction

	function automatic word_t sat_diff(word_t a, word_t b);
		return clamp_word(longint'(a) - longint'(b));
	endfunction

	// exact product, scaled down with truncation toward zero
	function automatic word_t fx_mul(word_t a, word_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp_word(p / (longint'(1) << FRAC_W));
	endfunction

	function automatic void reset_body();
		pos_x_q = '0;
		pos_y_q = '0;
		angle_q = '0;
		vel_x_q = '0;
		vel_y_q = '0;
		spin_q = '0;
		force_x_q = '0;
		force_y_q = '0;
		torque_q = '0;
		inv_mass_cfg = word_t'(INV_MASS_RST);
		inv_inertia_cfg = word_t'(INV_INR_RST);
		dt_cfg = word_t'(DT_RST);
		start_x_cfg = '0;
		start_y_cfg = '0;
		start_angle_cfg = '0;
	endfunction

	function automatic res_t integrate(req_t r);
		res_t  o;
		word_t rx, ry, tq;
		o = '0;
		case (r.opcode)
			OP_FORCE: begin
				force_x_q = sat_sum(force_x_q, r.force_x);
				force_y_q = sat_sum(force_y_q, r.force_y);
			end
			OP_CONTACT: begin
				rx = sat_diff(r.point_x, pos_x_q);
				ry = sat_diff(r.point_y, pos_y_q);
				tq = sat_diff(fx_mul(rx, r.force_y), fx_mul(ry, r.force_x));
				force_x_q = sat_sum(force_x_q, r.force_x);
				force_y_q = sat_sum(force_y_q, r.force_y);
				torque_q = sat_sum(torque_q, tq);
			end
			OP_STEP: begin
				if (inv_mass_cfg != '0) begin
					spin_q = sat_sum(spin_q, fx_mul(fx_mul(inv_inertia_cfg, torque_q), dt_cfg));
					angle_q = sat_sum(angle_q, fx_mul(spin_q, dt_cfg));
					vel_x_q = sat_sum(vel_x_q, fx_mul(fx_mul(inv_mass_cfg, force_x_q), dt_cfg));
					vel_y_q = sat_sum(vel_y_q, fx_mul(fx_mul(inv_mass_cfg, force_y_q), dt_cfg));
					pos_x_q = sat_sum(pos_x_q, fx_mul(vel_x_q, dt_cfg));
					pos_y_q = sat_sum(pos_y_q, fx_mul(vel_y_q, dt_cfg));
					steps_moving++;
				end else begin
					steps_static++;
				end
				force_x_q = '0;
				force_y_q = '0;
				torque_q = '0;
			end
			OP_RESET: begin
				pos_x_q = start_x_cfg;
				pos_y_q = start_y_cfg;
				angle_q = start_angle_cfg;
				vel_x_q = '0;
				vel_y_q = '0;
				spin_q = '0;
				force_x_q = '0;
				force_y_q = '0;
				torque_q = '0;
			end
			OP_QUERY: begin
				rx = sat_diff(r.point_x, pos_x_q);
				ry = sat_diff(r.point_y, pos_y_q);
				o.point_vel_x = sat_diff(vel_x_q, fx_mul(spin_q, ry));
				o.point_vel_y = sat_sum(vel_y_q, fx_mul(spin_q, rx));
			end
			default: begin
			end
		endcase
		o.pos_x = pos_x_q;
		o.pos_y = pos_y_q;
		o.angle = angle_q;
		o.vel_x = vel_x_q;
		o.vel_y = vel_y_q;
		o.spin = spin_q;
		return o;
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3, 4: return word_t'($urandom);
			default: return word_t'(int'($urandom_range(32'd2097152)) - 1048576);
		endcase
	endfunction

	task automatic queue_req(logic [OP_W-1:0] op, word_t px, word_t py, word_t fx, word_t fy);
		req_t r;
		r.opcode = op;
		r.point_x = px;
		r.point_y = py;
		r.force_x = fx;
		r.force_y = fy;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	task automatic queue_random(logic [OP_W-1:0] op);
		queue_req(op, pick_word(), pick_word(), pick_word(), pick_word());
	endtask

	// an optional reset, a burst of loads, optional queries, usually a step and now and then an unused opcode
	task automatic queue_frame();
		int adds;
		adds = $urandom_range(4);
		if ($urandom_range(19) == 0)
			queue_random(OP_RESET);
		repeat (adds)
			queue_random($urandom_range(1) ? OP_CONTACT : OP_FORCE);
		if ($urandom_range(2) == 0)
			queue_random(OP_QUERY);
		if ($urandom_range(9) != 0)
			queue_random(OP_STEP);
		if ($urandom_range(1) == 0)
			queue_random(OP_QUERY);
		if ($urandom_range(24) == 0)
			queue_random(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)));
	endtask

	task automatic queue_directed();
		queue_req(OP_QUERY, '0, '0, '0, '0);
		queue_req(OP_FORCE, '0, '0, WORD_MAX, WORD_MIN);
		queue_req(OP_FORCE, '1, '1, WORD_MAX, WORD_MIN);
		queue_req(OP_CONTACT, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
		queue_req(OP_STEP, WORD_MIN, WORD_MAX, '1, '1);
		queue_req(OP_QUERY, WORD_MIN, WORD_MAX, '0, '0);
		queue_req(OP_QUERY, WORD_MAX, WORD_MIN, '1, '1);
		queue_random(OP_SPARE_FIRST);
		queue_random(3'(OP_SPARE_FIRST + 3'd1));
		queue_random(OP_SPARE_LAST);
		queue_req(OP_CONTACT, word_t'(1), '1, '1, word_t'(1));
		queue_req(OP_STEP, '0, '0, '0, '0);
		queue_req(OP_STEP, '0, '0, '0, '0);
		queue_req(OP_STEP, '0, '0, '0, '0);
		queue_req(OP_RESET, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
		queue_req(OP_FORCE, '0, '0, ONE_Q, '0);
		queue_req(OP_CONTACT, ONE_Q, '0, '0, ONE_Q);
		queue_req(OP_STEP, '0, '0, '0, '0);
		queue_req(OP_STEP, '0, '0, '0, '0);
		queue_req(OP_QUERY, ONE_Q, ONE_Q, '0, '0);
		queue_req(OP_FORCE, '0, '0, '1, '1);
		queue_req(OP_STEP, '0, '0, '0, '0);
		queue_req(OP_QUERY, -ONE_Q, -ONE_Q, '0, '0);
		queue_req(OP_RESET, '0, '0, '0, '0);
	endtask

	task automatic write_reg(cfg_idx_t idx, word_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_INV_MASS:    inv_mass_cfg = data & UCFG_MASK;
			CFG_INV_INERTIA: inv_inertia_cfg = data & UCFG_MASK;
			CFG_TIME_STEP:   dt_cfg = data & UCFG_MASK;
			CFG_START_X:     start_x_cfg = data;
			CFG_START_Y:     start_y_cfg = data;
			CFG_START_ANGLE: start_angle_cfg = data;
			default: begin
			end
		endcase
	endtask

	task automatic configure_phase(int p);
		word_t m, ii, dt, sx, sy, sa;
		case (p)
			1: begin
				m = UCFG_MASK;
				ii = UCFG_MASK;
				dt = UCFG_MASK;
				sx = WORD_MAX;
				sy = WORD_MIN;
				sa = WORD_MAX;
			end
			2: begin
				// static body
				m = '0;
				ii = word_t'($urandom_range(32'h0010_0000, 1));
				dt = word_t'($urandom_range(32'h0001_0000, 1));
				sx = pick_word();
				sy = pick_word();
				sa = pick_word();
			end
			3: begin
				m = word_t'(1);
				ii = '0;
				dt = '0;
				sx = WORD_MIN;
				sy = WORD_MAX;
				sa = WORD_MIN;
			end
			4: begin
				m = word_t'($urandom_range(32'h0010_0000, 1));
				ii = word_t'($urandom_range(32'h0010_0000, 1));
				dt = word_t'($urandom_range(32'h0000_4000, 1));
				sx = word_t'(int'($urandom_range(32'd2097152)) - 1048576);
				sy = word_t'(int'($urandom_range(32'd2097152)) - 1048576);
				sa = word_t'(int'($urandom_range(32'd2097152)) - 1048576);
			end
			default: begin
				// raw words, top bit of the unsigned registers dropped by the block
				m = word_t'($urandom);
				ii = word_t'($urandom);
				dt = word_t'($urandom);
				sx = word_t'($urandom);
				sy = word_t'($urandom);
				sa = word_t'($urandom);
			end
		endcase
		write_reg(CFG_INV_MASS, m);
		write_reg(CFG_INV_INERTIA, ii);
		write_reg(CFG_TIME_STEP, dt);
		write_reg(CFG_START_X, sx);
		write_reg(CFG_START_Y, sy);
		write_reg(CFG_START_ANGLE, sa);
	endtask

	// request driver
	always @(posedge clk) begin
		logic busy;
		busy = req_valid;
		if (req_valid && !req_stall) begin
			awaited_states.push_back(integrate(req));
			busy = 1'b0;
		end
		if (!busy && arst_n) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, word_t want, word_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		res_t want;
		if (res_valid && !res_stall) begin
			if (awaited_states.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				mismatch_count++;
			end else begin
				want = awaited_states.pop_front();
				check_field("pos_x", want.pos_x, res.pos_x);
				check_field("pos_y", want.pos_y, res.pos_y);
				check_field("angle", want.angle, res.angle);
				check_field("vel_x", want.vel_x, res.vel_x);
				check_field("vel_y", want.vel_y, res.vel_y);
				check_field("spin", want.spin, res.spin);
				check_field("point_vel_x", want.point_vel_x, res.point_vel_x);
				check_field("point_vel_y", want.point_vel_y, res.point_vel_y);
				results_checked++;
			end
		end
		if (arst_n)
			res_stall <= ($urandom_range(99) < sink_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		reset_body();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			if (p < 2) begin
				src_idle_pct = 6;
				sink_idle_pct = 77;
			end else if (p < 4) begin
				src_idle_pct = 77;
				sink_idle_pct = 6;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if (p > 0)
				configure_phase(p);
			else
				queue_directed();
			while (reqs_queued < (p + 1) * REQS_PER_PHASE)
				queue_frame();
			while (pending_reqs.size() != 0 || req_valid || awaited_states.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
		$display("%0d requests checked over %0d register settings", results_checked, PHASES);
		$display("%0d moving steps, %0d static-body steps", steps_moving, steps_static);
		if (mismatch_count == 0 && awaited_states.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
